FILE: design/assert_macros.svh
// Assertion helpers for the design checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("port checker: assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port checker: assertion failed");

`endif

FILE: design/fis_pkg.sv
`default_nettype none

package fis_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned SCALED_W = 40;
  localparam int unsigned PROD_W   = DATA_W + SPEED_W;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SPEED       = 8'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd125000;
  localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd256;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: design/fis_store.sv
`default_nettype none

module fis_store import fis_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/fis_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant bit first.
module fis_divider import fis_pkg::*; #(
  parameter int unsigned DIVISOR_W = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [SUM_W-1:0]     dividend_i,
  input  wire logic [DIVISOR_W-1:0] divisor_i,
  output div_status_t               status_o,
  output logic      [DATA_W-1:0]    quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] div_q, div_d;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits the divisor width.
      rem_d  = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q[DATA_W-1:0];

endmodule

`default_nettype wire

FILE: design/frame_interval_smoother.sv
`default_nettype none

// Channel    Direction  Handshake              Payload
// in         input      in_valid_i/in_ready_o  timestamp_i
// out        output     out_valid_o/out_ready_i raw, smoothed, scaled interval, window count
// cfg        input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A transaction passes from acceptance through S_FULL (only when the window is full), S_PUSH,
// then S_SETTLE and S_EVICT once per evicted interval and once more, then S_DIV, S_MUL and
// S_DONE into the result register; S_DIV waits on the divider, skipped if fewer than two stay.
// Reset clears the sequencer, window state, settings and output valid; the store needs none.
// A result waiting on out_ready_i holds the sequencer in its last step; the input stays
// closed until that result is taken. Configuration writes are always taken.
module frame_interval_smoother import fis_pkg::*; #(
  parameter  int unsigned WINDOW_DEPTH = 64,
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH),
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [DATA_W-1:0]    timestamp_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [DATA_W-1:0]    raw_interval_o,
  output logic      [DATA_W-1:0]    smoothed_interval_o,
  output logic      [SCALED_W-1:0]  scaled_interval_o,
  output logic      [CNT_W-1:0]     window_count_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FULL   = 8'b0000_0010,
    S_PUSH   = 8'b0000_0100,
    S_SETTLE = 8'b0000_1000,
    S_EVICT  = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

  state_e              state_q, state_d;
  logic [DATA_W-1:0]   last_q, last_d;
  logic [DATA_W-1:0]   raw_q, raw_d;
  logic [IDX_W-1:0]    oldest_q, oldest_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PERIOD_W-1:0] period_q;
  logic [SPEED_W-1:0]  speed_q;
  logic [DATA_W-1:0]   smoothed_q, smoothed_d;
  logic [PROD_W-1:0]   product_q;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_raw_q;
  logic [DATA_W-1:0]   out_smoothed_q;
  logic [SCALED_W-1:0] out_scaled_q;
  logic [CNT_W-1:0]    out_count_q;

  logic [DATA_W-1:0]   rdata;
  logic [CNT_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    oldest_next;
  logic                evict;
  logic                div_start;
  logic                out_load;
  div_status_t         div_status;
  logic [DATA_W-1:0]   quotient;

  // Write slot is oldest plus fill, folded once into the ring.
  assign slot_sum    = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
  assign slot        = (slot_sum >= DEPTH_EXT) ? IDX_W'(slot_sum - DEPTH_EXT)
                                               : IDX_W'(slot_sum);
  assign oldest_next = (oldest_q == LAST_IDX) ? '0 : oldest_q + IDX_W'(1);
  assign evict       = (count_q != '0) && (sum_q > SUM_W'(period_q));

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    raw_d       = raw_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    sum_d       = sum_q;
    smoothed_d  = smoothed_q;
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          raw_d   = timestamp_i - last_q;
          last_d  = timestamp_i;
          state_d = (count_q == DEPTH_CNT) ? S_FULL : S_PUSH;
        end
      end
      S_FULL: begin
        sum_d    = sum_q - SUM_W'(rdata);
        oldest_d = oldest_next;
        count_d  = count_q - CNT_W'(1);
        state_d  = S_PUSH;
      end
      S_PUSH: begin
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_q + SUM_W'(raw_q);
        state_d = S_SETTLE;
      end
      // The store read is registered, so each move of the oldest pointer is
      // followed by S_SETTLE, in which the read catches up.
      S_SETTLE: begin
        state_d = S_EVICT;
      end
      S_EVICT: begin
        if (evict) begin
          sum_d    = sum_q - SUM_W'(rdata);
          oldest_d = oldest_next;
          count_d  = count_q - CNT_W'(1);
          state_d  = S_SETTLE;
        end else if (count_q > CNT_W'(1)) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          smoothed_d = raw_q;
          state_d    = S_MUL;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          smoothed_d = quotient;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      speed_q  <= SPEED_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SMOOTHING_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_TIME_SPEED:       speed_q  <= cfg_data_i[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    smoothed_q <= smoothed_d;
    if (state_q == S_MUL) begin
      product_q <= smoothed_q * speed_q;
    end
    if (out_load) begin
      out_raw_q      <= raw_q;
      out_smoothed_q <= smoothed_q;
      out_scaled_q   <= product_q[PROD_W-1:FRAC_W];
      out_count_q    <= count_q;
    end
  end

  fis_store #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_PUSH),
    .waddr_i (slot),
    .wdata_i (raw_q),
    .raddr_i (oldest_q),
    .rdata_o (rdata)
  );

  fis_divider #(
    .DIVISOR_W (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  assign out_valid_o         = out_valid_q;
  assign raw_interval_o      = out_raw_q;
  assign smoothed_interval_o = out_smoothed_q;
  assign scaled_interval_o   = out_scaled_q;
  assign window_count_o      = out_count_q;

endmodule

`default_nettype wire

FILE: design/fis_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fis_checker import fis_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [DATA_W-1:0]   raw_interval_i,
  input wire logic [DATA_W-1:0]   smoothed_interval_i,
  input wire logic [SCALED_W-1:0] scaled_interval_i,
  input wire logic [CNT_W-1:0]    window_count_i
);

  // A waiting result keeps its values until it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(raw_interval_i) && $stable(smoothed_interval_i) &&
    $stable(scaled_interval_i) && $stable(window_count_i))

  // An accepted transaction keeps the sequencer busy for the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  `ASSERT_ALWAYS(a_count_bound,
    !out_valid_i || (window_count_i <= CNT_W'(WINDOW_DEPTH)))

  // With fewer than two intervals kept the smoothed value is the raw one.
  `ASSERT_ALWAYS(a_raw_passthrough,
    !(out_valid_i && (window_count_i < CNT_W'(2))) ||
    (smoothed_interval_i == raw_interval_i))

endmodule

bind frame_interval_smoother fis_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH),
  .CNT_W        (CNT_W)
) u_fis_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_i          (in_ready_o),
  .out_valid_i         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .raw_interval_i      (raw_interval_o),
  .smoothed_interval_i (smoothed_interval_o),
  .scaled_interval_i   (scaled_interval_o),
  .window_count_i      (window_count_o)
);

`default_nettype wire

FILE: bench/interval_checker.sv
`default_nettype none

// Watches the three channels of the smoother, keeps its own copy of the interval window and
// compares every result transaction against the oldest outstanding prediction.
module interval_checker import fis_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [DATA_W-1:0]    timestamp_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [DATA_W-1:0]    raw_interval_i,
  input  wire logic [DATA_W-1:0]    smoothed_interval_i,
  input  wire logic [SCALED_W-1:0]  scaled_interval_i,
  input  wire logic [CNT_W-1:0]     window_count_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0]   raw;
    logic [DATA_W-1:0]   smoothed;
    logic [SCALED_W-1:0] scaled;
    logic [CNT_W-1:0]    count;
  } interval_result_t;

  logic [PERIOD_W-1:0] period_q;
  logic [SPEED_W-1:0]  speed_q;
  logic [DATA_W-1:0]   last_stamp;
  logic [DATA_W-1:0]   interval_mem [WINDOW_DEPTH];
  int unsigned         head_idx;
  int unsigned         kept;
  logic [63:0]         kept_sum;
  interval_result_t    pending_intervals [$];

  task automatic report_mismatch(input string msg);
    // Printing stops after a hundred lines so that a badly broken build stays readable.
    if (errors_o < 100) begin
      $display("%0t: %s", $time, msg);
    end
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got != want) begin
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic drop_oldest_interval();
    if (kept != 0) begin
      kept_sum -= 64'(interval_mem[head_idx]);
      head_idx = (head_idx + 1) % WINDOW_DEPTH;
      kept--;
    end
  endtask

  task automatic smooth_next_interval(input logic [DATA_W-1:0] stamp,
                                      output interval_result_t res);
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] mean;
    logic [PROD_W-1:0] prod;
    raw = stamp - last_stamp;
    last_stamp = stamp;
    if (kept >= WINDOW_DEPTH) begin
      drop_oldest_interval();
    end
    interval_mem[(head_idx + kept) % WINDOW_DEPTH] = raw;
    kept++;
    kept_sum += 64'(raw);
    // A single interval longer than the period is evicted as well.
    while (kept != 0 && kept_sum > 64'(period_q)) begin
      drop_oldest_interval();
    end
    if (kept > 1) begin
      mean = DATA_W'(kept_sum / 64'(kept));
    end else begin
      mean = raw;
    end
    prod = PROD_W'(mean) * PROD_W'(speed_q);
    res.raw      = raw;
    res.smoothed = mean;
    res.scaled   = SCALED_W'(prod >> FRAC_W);
    res.count    = CNT_W'(kept);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    interval_result_t want;
    if (!rst_ni) begin
      period_q   = PERIOD_RESET;
      speed_q    = SPEED_RESET;
      last_stamp = '0;
      head_idx   = 0;
      kept       = 0;
      kept_sum   = '0;
      pending_intervals.delete();
      pending_o  = 0;
      errors_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SMOOTHING_PERIOD: period_q = cfg_data_i[PERIOD_W-1:0];
          CFG_TIME_SPEED:       speed_q  = cfg_data_i[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_intervals.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: raw 0x%0h",
                                    raw_interval_i));
        end else begin
          want = pending_intervals.pop_front();
          check_field("raw_interval", 64'(raw_interval_i), 64'(want.raw));
          check_field("smoothed_interval", 64'(smoothed_interval_i), 64'(want.smoothed));
          check_field("scaled_interval", 64'(scaled_interval_i), 64'(want.scaled));
          check_field("window_count", 64'(window_count_i), 64'(want.count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        smooth_next_interval(timestamp_i, want);
        pending_intervals.insert(pending_intervals.size(), want);
      end
      pending_o = pending_intervals.size();
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
  import fis_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 250;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [DATA_W-1:0]    timestamp_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DATA_W-1:0]    raw_interval_o;
  logic [DATA_W-1:0]    smoothed_interval_o;
  logic [SCALED_W-1:0]  scaled_interval_o;
  logic [CNT_W-1:0]     window_count_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  int unsigned          pending;
  int unsigned          errors;
  logic [DATA_W-1:0]    now_us = '0;
  bit                   calm   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frame_interval_smoother #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .timestamp_i        (timestamp_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .raw_interval_o     (raw_interval_o),
    .smoothed_interval_o(smoothed_interval_o),
    .scaled_interval_o  (scaled_interval_o),
    .window_count_o     (window_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  interval_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .timestamp_i        (timestamp_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .raw_interval_i     (raw_interval_o),
    .smoothed_interval_i(smoothed_interval_o),
    .scaled_interval_i  (scaled_interval_o),
    .window_count_i     (window_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .pending_o          (pending),
    .errors_o           (errors)
  );

  function automatic int unsigned pick_gap(input bit calm_mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Intervals are drawn relative to the period, so that the window settles near the
  // target length, with some short, some around the period and some wild ones.
  function automatic logic [DATA_W-1:0] pick_interval(input int unsigned period,
                                                      input int unsigned target);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, (2 * period) / target + 1);
    if (r < 75) return $urandom_range(0, 3);
    if (r < 88) return $urandom_range(period / 2, period + period / 2 + 1);
    return $urandom();
  endfunction

  // Ready is sampled at the falling edge, where it already holds the value that the
  // next rising edge will see.
  task automatic send_stamp(input logic [DATA_W-1:0] stamp);
    int unsigned gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    timestamp_i <= stamp;
    now_us = stamp;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_interval(input logic [DATA_W-1:0] dt);
    send_stamp(now_us + dt);
  endtask

  // Registers are only written once every outstanding result has been taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    bit          burst;
    @(posedge rst_ni);
    forever begin
      burst = ($urandom_range(0, 19) == 0);
      n = burst ? 0 : pick_gap(1'b0);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (burst ? $urandom_range(100, 300) : $urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned       period;
    int unsigned       speed;
    int unsigned       target;
    logic [DATA_W-1:0] cfg_word;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_stamp(32'd16667);
    send_interval(32'd16667);
    send_interval(32'd16666);
    send_interval(32'd16667);
    send_interval(32'd0);
    send_interval(32'd200000);
    send_stamp(32'hFFFF_FFF0);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0100);

    // Upper data bits are set to show that only the register width is taken.
    write_reg(CFG_SMOOTHING_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_TIME_SPEED, 32'hFFFF_FFFF);
    send_interval(32'd1000);
    send_interval(32'd2000);
    send_interval(32'd3);
    send_interval(32'hFFFF_FFFF);

    write_reg(CFG_TIME_SPEED, 32'h0);
    write_reg(CFG_SMOOTHING_PERIOD, 32'd1);
    send_interval(32'd1);
    send_interval(32'd0);
    send_interval(32'd1);
    send_interval(32'd2);

    // A zero period keeps only zero-length intervals.
    write_reg(CFG_SMOOTHING_PERIOD, 32'h0100_0000);
    send_interval(32'd0);
    send_interval(32'd0);
    send_interval(32'd5);

    write_reg(CFG_IDX_W'(2), 32'h5555_5555);
    write_reg(CFG_IDX_W'(255), 32'hAAAA_AAAA);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin period = 125000;    speed = 256;                    target = 8;   end
        1: begin period = 24'hFFFFFF; speed = $urandom_range(0, 65535); target = 100; end
        2: begin period = 1;         speed = 65535;                  target = 1;   end
        3: begin period = 0;         speed = 0;                      target = 1;   end
        default: begin
          period = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 24'hFFFFFF)
                                               : $urandom_range(1, 5000);
          speed  = $urandom_range(0, 65535);
          target = $urandom_range(2, 90);
        end
      endcase
      cfg_word = $urandom();
      cfg_word[PERIOD_W-1:0] = PERIOD_W'(period);
      write_reg(CFG_SMOOTHING_PERIOD, cfg_word);
      cfg_word = $urandom();
      cfg_word[SPEED_W-1:0] = SPEED_W'(speed);
      write_reg(CFG_TIME_SPEED, cfg_word);
      if (ph >= 4) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0) begin
          send_stamp($urandom());
        end else begin
          send_interval(pick_interval(period, target));
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
